// ===== rtl/core/dhtd_pkg.sv =====
`timescale 1ns / 1ps

package dhtd_pkg;

    // Read sequence phase
    typedef enum logic [1:0] {
        PH_STOPPED  = 2'd0,
        PH_RESPONSE = 2'd1,
        PH_DATA     = 2'd2,
        PH_ACQUIRED = 2'd3
    } t_phase;

    // Status codes reported with every result
    typedef enum logic [2:0] {
        ST_NOT_STARTED  = 3'd0,
        ST_OK           = 3'd1,
        ST_CHECKSUM     = 3'd2,
        ST_RESP_TIMEOUT = 3'd3,
        ST_DATA_TIMEOUT = 3'd4,
        ST_EDGE_TIMEOUT = 3'd5,
        ST_GLITCH       = 3'd6
    } t_status;

    // Input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_EDGE  = 1'b1;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SENSOR_KIND   = 2'd0;
    localparam logic [1:0] REG_ONE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_EDGE_TIMEOUT  = 2'd2;
    localparam logic [1:0] REG_RESPONSE_MAX  = 2'd3;

    // Register reset values
    localparam logic        RST_SENSOR_KIND   = 1'b1;
    localparam logic [7:0]  RST_ONE_THRESHOLD = 8'd110;
    localparam logic [15:0] RST_EDGE_TIMEOUT  = 16'd6000;
    localparam logic [9:0]  RST_RESPONSE_MAX  = 10'd220;

    // Fixed timing windows in microseconds
    localparam logic [31:0] RESP_EARLY_US = 32'd65;
    localparam logic [31:0] RESP_MIN_US   = 32'd125;
    localparam logic [31:0] BIT_MIN_US    = 32'd60;
    localparam logic [31:0] BIT_MAX_US    = 32'd155;
    localparam logic [31:0] GLITCH_US     = 32'd10;

    // Frame layout
    localparam int unsigned FRAME_BITS  = 40;
    localparam logic [2:0]  LAST_BYTE   = 3'd5;
    localparam logic [2:0]  BIT_TOP     = 3'd7;

endpackage

// ===== rtl/core/dht_edge_timing_decoder_unit.sv =====
`timescale 1ns / 1ps

// DHT11/21/22 single-wire reply decoder working on falling-edge timestamps.
// Input stream: s_axis_tuser selects start (0) or falling edge (1), and
// s_axis_tdata carries the 32-bit microsecond timestamp of the event.
// Every input transfer yields exactly one result transfer on m_axis with the
// current status, busy flag, start-refused flag, reading-valid flag and the
// latched humidity and temperature in tenths.
// Timing: an accepted item is held in the input register, and its result is
// loaded into the output register once that register is free or drains; the
// result is driven on m_axis from the output register.
// Throughput: one item per cycle while the receiver takes every result; the
// decode (one 32-bit subtract, window compares, shift and byte-sum check) is
// a single pass between the two registers.
// When the receiver stalls the output register holds its result and the
// input register still takes one more item; s_axis_tready drops only when
// both are full.
// Reset (i_rst_n low, synchronous) empties both stages, stops any read,
// clears status and readings, and restores the register defaults.
// The APB port writes settings at 4*index; write only while the stream is idle.
module dht_edge_timing_decoder_unit
    import dhtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] time_us
    input  logic        s_axis_tuser,   // [0] command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [3] busy_res, [4] start_refused, [5] reading_valid,
    // [21:6] humidity_tenths, [37:22] temperature_tenths, [39:38] zero
    output logic [39:0] m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic        r_sensor_kind;
    logic [7:0]  r_one_threshold;
    logic [15:0] r_edge_timeout;
    logic [9:0]  r_response_max;

    // input stage
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [31:0] r_in_time;

    // decoder state
    t_phase                  r_phase, n_phase;
    logic [31:0]             r_ref_time, n_ref_time;
    logic [FRAME_BITS-1:0]   r_frame, n_frame;
    logic [2:0]              r_bit_cnt, n_bit_cnt;
    logic [2:0]              r_byte_idx, n_byte_idx;
    t_status                 r_status, n_status;
    logic [15:0]             r_humidity, n_humidity;
    logic [15:0]             r_temperature, n_temperature;
    logic                    n_refused;

    // output stage
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic [39:0] n_out_data;

    logic        advance;
    logic        busy;
    logic [31:0] delta;
    logic        bit_val;
    logic [2:0]  byte_inc;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic [14:0] mag;
    logic [1:0]  reg_idx;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_kind   <= RST_SENSOR_KIND;
            r_one_threshold <= RST_ONE_THRESHOLD;
            r_edge_timeout  <= RST_EDGE_TIMEOUT;
            r_response_max  <= RST_RESPONSE_MAX;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_SENSOR_KIND:   r_sensor_kind   <= pwdata[0];
                REG_ONE_THRESHOLD: r_one_threshold <= pwdata[7:0];
                REG_EDGE_TIMEOUT:  r_edge_timeout  <= pwdata[15:0];
                REG_RESPONSE_MAX:  r_response_max  <= pwdata[9:0];
                default:           r_sensor_kind   <= r_sensor_kind;
            endcase
        end
    end

    // read back configuration registers
    always_comb begin
        unique case (reg_idx)
            REG_SENSOR_KIND:   prdata = {31'd0, r_sensor_kind};
            REG_ONE_THRESHOLD: prdata = {24'd0, r_one_threshold};
            REG_EDGE_TIMEOUT:  prdata = {16'd0, r_edge_timeout};
            REG_RESPONSE_MAX:  prdata = {22'd0, r_response_max};
            default:           prdata = 32'd0;
        endcase
    end

    // stream handshake: decode whenever the output register is free or drains
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign busy     = (r_phase == PH_RESPONSE) || (r_phase == PH_DATA);
    assign delta    = r_in_time - r_ref_time;
    assign bit_val  = delta > {24'd0, r_one_threshold};
    assign byte_inc = r_byte_idx + 3'd1;

    // bytes of the frame after the current bit is shifted in
    assign b0  = n_frame[39:32];
    assign b1  = n_frame[31:24];
    assign b2  = n_frame[23:16];
    assign b3  = n_frame[15:8];
    assign b4  = n_frame[7:0];
    assign sum = b0 + b1 + b2 + b3;
    assign mag = {b2[6:0], b3};

    // next state of the decoder for the item in the input register
    always_comb begin
        n_phase       = r_phase;
        n_ref_time    = r_ref_time;
        n_frame       = r_frame;
        n_bit_cnt     = r_bit_cnt;
        n_byte_idx    = r_byte_idx;
        n_status      = r_status;
        n_humidity    = r_humidity;
        n_temperature = r_temperature;
        n_refused     = 1'b0;
        if (r_in_cmd == CMD_START) begin
            if (busy) begin
                n_refused = 1'b1;
            end else begin
                n_phase       = PH_RESPONSE;
                n_frame       = '0;
                n_bit_cnt     = BIT_TOP;
                n_byte_idx    = 3'd0;
                n_humidity    = 16'd0;
                n_temperature = 16'd0;
                n_ref_time    = r_in_time;
            end
        end else if (busy) begin
            n_ref_time = r_in_time;
            priority if (delta > {16'd0, r_edge_timeout}) begin
                n_status = ST_EDGE_TIMEOUT;
                n_phase  = PH_STOPPED;
            end else if (r_phase == PH_RESPONSE) begin
                priority if (delta < RESP_EARLY_US) begin
                    // early edge: keep the old reference
                    n_ref_time = r_ref_time;
                end else if (delta > RESP_MIN_US && delta < {22'd0, r_response_max}) begin
                    n_phase = PH_DATA;
                end else begin
                    n_status = ST_RESP_TIMEOUT;
                    n_phase  = PH_STOPPED;
                end
            end else if (delta > BIT_MIN_US && delta < BIT_MAX_US) begin
                n_frame = {r_frame[FRAME_BITS-2:0], bit_val};
                if (r_bit_cnt == 3'd0) begin
                    n_bit_cnt  = BIT_TOP;
                    n_byte_idx = byte_inc;
                    if (byte_inc == LAST_BYTE) begin
                        // full frame: check the byte sum and convert
                        if (sum != b4) begin
                            n_status = ST_CHECKSUM;
                            n_phase  = PH_STOPPED;
                        end else begin
                            n_status = ST_OK;
                            n_phase  = PH_ACQUIRED;
                            if (!r_sensor_kind) begin
                                n_humidity    = ({8'd0, b0} << 3) + ({8'd0, b0} << 1);
                                n_temperature = ({8'd0, b2} << 3) + ({8'd0, b2} << 1);
                            end else begin
                                n_humidity    = {b0, b1};
                                n_temperature = b2[7] ? (16'd0 - {1'b0, mag})
                                                      : {1'b0, mag};
                            end
                        end
                    end
                end else begin
                    n_bit_cnt = r_bit_cnt - 3'd1;
                end
            end else if (delta < GLITCH_US) begin
                n_status = ST_GLITCH;
                n_phase  = PH_STOPPED;
            end else begin
                n_status = ST_DATA_TIMEOUT;
                n_phase  = PH_STOPPED;
            end
        end
    end

    // result fields from the updated state
    always_comb begin
        n_out_data = {2'd0, n_temperature, n_humidity,
                      n_phase == PH_ACQUIRED, n_refused,
                      (n_phase == PH_RESPONSE) || (n_phase == PH_DATA),
                      n_status};
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_time <= s_axis_tdata;
        end
    end

    // decoder state, advanced once per decoded item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_STOPPED;
            r_ref_time    <= 32'd0;
            r_frame       <= '0;
            r_bit_cnt     <= BIT_TOP;
            r_byte_idx    <= 3'd0;
            r_status      <= ST_NOT_STARTED;
            r_humidity    <= 16'd0;
            r_temperature <= 16'd0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_ref_time    <= n_ref_time;
            r_frame       <= n_frame;
            r_bit_cnt     <= n_bit_cnt;
            r_byte_idx    <= n_byte_idx;
            r_status      <= n_status;
            r_humidity    <= n_humidity;
            r_temperature <= n_temperature;
        end
    end

    // output register: load on decode, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // a refused start never changes a running read
    a_refused_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3])
        else $error("start refused while not busy");

    // a valid reading always comes with an ok status
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[2:0] == ST_OK
                                           && !m_axis_tdata[3])
        else $error("reading valid without ok status");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // a decode always leaves a result in the output register
    a_decode_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("decoded item without result");
`endif

endmodule

// ===== tb/sv/dhtd_checker.sv =====
`timescale 1ns / 1ps

module dhtd_checker
    import dhtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] time_us
    input  logic        s_axis_tuser,   // [0] command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [3] busy_res, [4] start_refused, [5] reading_valid,
    // [21:6] humidity_tenths, [37:22] temperature_tenths, [39:38] zero
    input  logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_err_count,
    output int          o_pending
);

    // One result transfer, laid out as on m_axis_tdata[37:0]
    typedef struct packed {
        logic [15:0] temperature;
        logic [15:0] humidity;
        logic        reading_valid;
        logic        start_refused;
        logic        busy;
        t_status     status;
    } t_reading;

    // Settings as seen on the configuration port
    logic        kind;
    logic [7:0]  one_thr;
    logic [15:0] edge_tmo;
    logic [9:0]  resp_max;

    // Decoder state
    t_phase      phase;
    logic [31:0] ref_us;
    logic [39:0] frame;
    logic [2:0]  bits_left;
    logic [2:0]  byte_cnt;
    t_status     status_r;
    logic [15:0] hum_r;
    logic [15:0] temp_r;

    t_reading    readings_due[$];
    int          errs = 0;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    // Advance the decoder by one event and return the reading it reports
    function automatic t_reading decode_event(logic cmd, logic [31:0] stamp);
        t_reading    r;
        logic [31:0] span;
        logic [7:0]  b0, b1, b2, b3, sum;
        logic [14:0] mag;
        logic        refused;
        refused = 1'b0;
        if (cmd == CMD_START) begin
            if (phase == PH_RESPONSE || phase == PH_DATA) begin
                refused = 1'b1;
            end else begin
                phase     = PH_RESPONSE;
                frame     = '0;
                bits_left = BIT_TOP;
                byte_cnt  = '0;
                hum_r     = '0;
                temp_r    = '0;
                ref_us    = stamp;
            end
        end else if (phase == PH_RESPONSE || phase == PH_DATA) begin
            span   = stamp - ref_us;
            ref_us = stamp;
            if (span > {16'd0, edge_tmo}) begin
                status_r = ST_EDGE_TIMEOUT;
                phase    = PH_STOPPED;
            end else if (phase == PH_RESPONSE) begin
                // early edge keeps the old reference
                if (span < RESP_EARLY_US) begin
                    ref_us = stamp - span;
                end else if (span > RESP_MIN_US && span < {22'd0, resp_max}) begin
                    phase = PH_DATA;
                end else begin
                    status_r = ST_RESP_TIMEOUT;
                    phase    = PH_STOPPED;
                end
            end else if (span > BIT_MIN_US && span < BIT_MAX_US) begin
                frame = {frame[38:0], (span > {24'd0, one_thr})};
                if (bits_left != 3'd0) begin
                    bits_left = bits_left - 3'd1;
                end else begin
                    bits_left = BIT_TOP;
                    byte_cnt  = byte_cnt + 3'd1;
                    if (byte_cnt == LAST_BYTE) begin
                        {b0, b1, b2, b3} = frame[39:8];
                        sum = b0 + b1 + b2 + b3;
                        if (sum != frame[7:0]) begin
                            status_r = ST_CHECKSUM;
                            phase    = PH_STOPPED;
                        end else begin
                            status_r = ST_OK;
                            phase    = PH_ACQUIRED;
                            if (kind == 1'b0) begin
                                hum_r  = b0 * 16'd10;
                                temp_r = b2 * 16'd10;
                            end else begin
                                // sign-magnitude to two's complement
                                mag    = {b2[6:0], b3};
                                hum_r  = {b0, b1};
                                temp_r = b2[7] ? 16'd0 - {1'b0, mag} : {1'b0, mag};
                            end
                        end
                    end
                end
            end else if (span < GLITCH_US) begin
                status_r = ST_GLITCH;
                phase    = PH_STOPPED;
            end else begin
                status_r = ST_DATA_TIMEOUT;
                phase    = PH_STOPPED;
            end
        end
        r.status        = status_r;
        r.busy          = (phase == PH_RESPONSE || phase == PH_DATA);
        r.start_refused = refused;
        r.reading_valid = (phase == PH_ACQUIRED);
        r.humidity      = hum_r;
        r.temperature   = temp_r;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want_v, got_v);
            errs++;
        end
    endtask

    // Watch the configuration port and both streams
    always @(posedge i_clk) begin : watch_channels
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            kind      = RST_SENSOR_KIND;
            one_thr   = RST_ONE_THRESHOLD;
            edge_tmo  = RST_EDGE_TIMEOUT;
            resp_max  = RST_RESPONSE_MAX;
            phase     = PH_STOPPED;
            ref_us    = '0;
            frame     = '0;
            bits_left = BIT_TOP;
            byte_cnt  = '0;
            status_r  = ST_NOT_STARTED;
            hum_r     = '0;
            temp_r    = '0;
            readings_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SENSOR_KIND:   kind     = pwdata[0];
                    REG_ONE_THRESHOLD: one_thr  = pwdata[7:0];
                    REG_EDGE_TIMEOUT:  edge_tmo = pwdata[15:0];
                    REG_RESPONSE_MAX:  resp_max = pwdata[9:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                readings_due.push_back(decode_event(s_axis_tuser, s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[37:0];
                if (readings_due.size() == 0) begin
                    $display("%0t ns: no result expected, got %h", $time, m_axis_tdata);
                    errs++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("busy_res", 16'(want.busy), 16'(got.busy));
                    check_field("start_refused", 16'(want.start_refused),
                                16'(got.start_refused));
                    check_field("reading_valid", 16'(want.reading_valid),
                                16'(got.reading_valid));
                    check_field("humidity_tenths", want.humidity, got.humidity);
                    check_field("temperature_tenths", want.temperature, got.temperature);
                    check_field("pad", 16'd0, {14'd0, m_axis_tdata[39:38]});
                end
            end
        end
        o_pending   <= readings_due.size();
        o_err_count <= errs;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dhtd_pkg::*;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] time_us
    logic        s_axis_tuser  = 1'b0;  // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] status, [3] busy_res, [4] start_refused, [5] reading_valid,
    // [21:6] humidity_tenths, [37:22] temperature_tenths, [39:38] zero
    logic [39:0] m_axis_tdata;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int          err_count;
    int          pending;
    int          src_idle_pct = 0;
    int          dst_idle_pct = 0;
    int          items_sent   = 0;
    logic [31:0] event_us;
    logic [7:0]  one_thr  = RST_ONE_THRESHOLD;
    logic [15:0] edge_tmo = RST_EDGE_TIMEOUT;

    dht_edge_timing_decoder_unit u_dut (.*);

    dhtd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_err_count   (err_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result stream at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Hand one event to the decoder and hold it until the transfer
    task automatic push_event(input logic cmd, input logic [31:0] stamp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= stamp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop the input and let every outstanding result come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup and access cycle; psel is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // One full sensor reply, now and then broken, with a refused start or stray edges
    task automatic send_frame();
        logic [7:0]  bytes_in [4];
        logic [7:0]  check;
        logic [39:0] payload;
        logic [31:0] mark;
        logic [31:0] span;
        int          break_at;
        int          lo;
        int          hi;
        foreach (bytes_in[k]) bytes_in[k] = 8'($urandom_range(255));
        check = bytes_in[0] + bytes_in[1] + bytes_in[2] + bytes_in[3];
        if ($urandom_range(7) == 0) check = 8'($urandom_range(255));
        payload  = {bytes_in[0], bytes_in[1], bytes_in[2], bytes_in[3], check};
        break_at = ($urandom_range(5) == 0) ? int'($urandom_range(40)) : -1;
        mark     = event_us;
        push_event(CMD_START, mark);
        if ($urandom_range(4) == 0) push_event(CMD_EDGE, mark + $urandom_range(64));
        for (int k = 0; k <= 40; k++) begin
            if (k == break_at) begin
                case ($urandom_range(3))
                    0:       span = $urandom_range(9);
                    1:       span = (k == 0) ? $urandom_range(125, 65) : $urandom_range(60, 10);
                    2:       span = (k == 0) ? $urandom_range(1023, 220) : $urandom_range(400, 155);
                    default: span = edge_tmo + 1 + $urandom_range(2000);
                endcase
            end else if (k == 0) begin
                span = $urandom_range(219, 126);
            end else if (payload[40 - k]) begin
                lo = int'(one_thr) + 1;
                if (lo < 61 || lo > 154) lo = 61;
                span = $urandom_range(154, lo);
            end else begin
                hi = int'(one_thr);
                if (hi > 154) hi = 154;
                if (hi < 61) hi = 154;
                span = $urandom_range(hi, 61);
            end
            if ($urandom_range(29) == 0) push_event(CMD_START, $urandom());
            mark = mark + span;
            push_event(CMD_EDGE, mark);
            if (k == break_at) break;
        end
        if ($urandom_range(3) == 0) push_event(CMD_EDGE, mark + $urandom_range(300));
        event_us = mark + $urandom_range(5000, 100);
        if ($urandom_range(9) == 0) event_us = $urandom();
    endtask

    // Mostly well-formed replies, the rest random events
    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                send_frame();
            end else begin
                repeat ($urandom_range(4, 1)) push_event(1'($urandom_range(1)), $urandom());
            end
        end
    endtask

    // Reconfigure while idle, then run random traffic with the given stall rates
    task automatic next_phase(input logic kind, input logic [7:0] thr, input logic [15:0] tmo,
                              input logic [9:0] rmax, input int src_pct, input int dst_pct,
                              input int count);
        drain();
        write_reg(REG_SENSOR_KIND, {31'd0, kind});
        write_reg(REG_ONE_THRESHOLD, {24'd0, thr});
        write_reg(REG_EDGE_TIMEOUT, {16'd0, tmo});
        write_reg(REG_RESPONSE_MAX, {22'd0, rmax});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        one_thr  = thr;
        edge_tmo = tmo;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        run_random(count);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        event_us     = $urandom();
        src_idle_pct = 11;
        dst_idle_pct = 47;

        // Directed events under the reset settings
        push_event(CMD_EDGE, 32'h0000_0000);      // edge while stopped
        push_event(CMD_EDGE, 32'hFFFF_FFFF);
        push_event(CMD_START, 32'hFFFF_FF80);
        push_event(CMD_START, 32'hFFFF_FF90);     // start while busy
        push_event(CMD_EDGE, 32'hFFFF_FFC0);      // early response edge
        push_event(CMD_EDGE, 32'h0000_0010);      // response across the wrap
        push_event(CMD_EDGE, 32'h0000_0019);      // glitch
        push_event(CMD_START, 32'd1000);
        push_event(CMD_EDGE, 32'd1065);           // response too short
        push_event(CMD_START, 32'd2000);
        push_event(CMD_EDGE, 32'd2125);           // response at lower bound
        push_event(CMD_START, 32'd3000);
        push_event(CMD_EDGE, 32'd3220);           // response at upper bound
        push_event(CMD_START, 32'd4000);
        push_event(CMD_EDGE, 32'd4219);
        push_event(CMD_EDGE, 32'd4279);           // bit at lower bound
        push_event(CMD_START, 32'd5000);
        push_event(CMD_EDGE, 32'd5126);
        push_event(CMD_EDGE, 32'd5281);           // bit at upper bound
        push_event(CMD_START, 32'd6000);
        push_event(CMD_EDGE, 32'd12001);          // edge timeout
        push_event(CMD_START, 32'd20000);
        push_event(CMD_EDGE, 32'd26000);          // timeout limit itself
        push_event(CMD_EDGE, 32'd26100);          // edge after stop
        run_random(110);

        next_phase(1'b0, RST_ONE_THRESHOLD, RST_EDGE_TIMEOUT, RST_RESPONSE_MAX, 11, 47, 160);
        next_phase(1'b1, 8'd0, 16'hFFFF, 10'h3FF, 47, 11, 160);
        next_phase(1'b0, 8'hFF, 16'd0, 10'd0, 47, 11, 60);
        next_phase(1'($urandom_range(1)), 8'($urandom_range(150, 70)),
                   16'($urandom_range(65535, 200)), 10'($urandom_range(1023, 130)),
                   0, 0, 160);
        next_phase(RST_SENSOR_KIND, RST_ONE_THRESHOLD, RST_EDGE_TIMEOUT, RST_RESPONSE_MAX,
                   0, 0, 160);

        drain();
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
